// ----- rtl/core/ffa_pkg.sv -----
`timescale 1ns / 1ps

package ffa_pkg;

    localparam int OFS_W           = 32;
    localparam int PAD_W           = 8;
    localparam int ALIGN_W         = 9;
    localparam int MIN_ALIGN       = 4;
    localparam int FREE_SLOTS_DEF  = 64;
    localparam int ALLOC_SLOTS_DEF = 64;
    localparam int PADDR_W         = 3;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CHECK = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_MEMORY  = 3'd1,
        ST_BAD_ALIGN  = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_ALLOC_FULL = 3'd4,
        ST_FREE_FULL  = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        REG_BASE  = 1'b0,
        REG_BYTES = 1'b1
    } t_reg;

    typedef struct packed {
        logic [OFS_W-1:0] base;
        logic [OFS_W-1:0] bytes;
    } t_cfg;

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] len;
    } t_free;

    typedef struct packed {
        logic [OFS_W-1:0] addr;
        logic [OFS_W-1:0] len;
        logic [PAD_W-1:0] pad;
    } t_alloc;

endpackage

// ----- rtl/core/ffa_apb.sv -----
`timescale 1ns / 1ps

module ffa_apb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffa_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output ffa_pkg::t_cfg                o_cfg
);
    import ffa_pkg::*;

    logic [OFS_W-1:0] r_base;
    logic [OFS_W-1:0] r_bytes;
    logic             wr_en;
    t_reg             sel;

    assign sel    = t_reg'(paddr[2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_bytes <= '0;
        end else if (wr_en) begin
            case (sel)
                REG_BASE:  r_base  <= pwdata;
                REG_BYTES: r_bytes <= pwdata;
                default:   r_base  <= r_base;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_BASE:  prdata = r_base;
            REG_BYTES: prdata = r_bytes;
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.base  = r_base;
    assign o_cfg.bytes = r_bytes;

endmodule

// ----- rtl/core/ffa_ctrl.sv -----
`timescale 1ns / 1ps

module ffa_ctrl #(
    parameter int FREE_SLOTS  = ffa_pkg::FREE_SLOTS_DEF,
    parameter int ALLOC_SLOTS = ffa_pkg::ALLOC_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffa_pkg::t_cfg               i_cfg,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_opcode,
    input  logic [ffa_pkg::OFS_W-1:0]   i_request_bytes,
    input  logic [ffa_pkg::ALIGN_W-1:0] i_align_bytes,
    input  logic [ffa_pkg::OFS_W-1:0]   i_target_address,
    output logic                        o_done,
    output logic [2:0]                  o_status,
    output logic [ffa_pkg::OFS_W-1:0]   o_data_address,
    output logic                        o_range_inside,
    output logic [ffa_pkg::OFS_W-1:0]   o_used_bytes,
    output logic [ffa_pkg::OFS_W-1:0]   o_peak_bytes
);
    import ffa_pkg::*;

    localparam int FIW = $clog2(FREE_SLOTS);
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int AIW = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
    localparam int ACW = $clog2(ALLOC_SLOTS + 1);
    localparam int PW  = (FCW > ACW) ? FCW : ACW;

    typedef enum logic [12:0] {
        S_INIT     = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_CLR      = 13'b0000000000100,
        S_AL_SCAN  = 13'b0000000001000,
        S_AL_SLOT  = 13'b0000000010000,
        S_AL_UPD   = 13'b0000000100000,
        S_SHIFT_DN = 13'b0000001000000,
        S_FR_FIND  = 13'b0000010000000,
        S_FR_SCAN  = 13'b0000100000000,
        S_FR_UPD   = 13'b0001000000000,
        S_SHIFT_UP = 13'b0010000000000,
        S_CK_SCAN  = 13'b0100000000000,
        S_CK_EVAL  = 13'b1000000000000
    } t_state;

    t_free  free_mem  [FREE_SLOTS];
    t_alloc alloc_mem [ALLOC_SLOTS];

    t_free            fr_q, fr_wd;
    logic             fr_we;
    logic [FIW-1:0]   fr_wa, fr_ra;
    t_alloc           al_q, al_wd;
    logic             al_we;
    logic [AIW-1:0]   al_wa, al_ra;

    t_state             r_state, n_state;
    logic [FCW-1:0]     r_count, n_count;
    logic [ALLOC_SLOTS-1:0] r_valid, n_valid;
    logic [OFS_W-1:0]   r_used, n_used, r_peak, n_peak;
    logic [PW-1:0]      r_ptr, n_ptr, r_di, n_di;
    logic               r_dv, n_dv;
    logic [FCW-1:0]     r_lim, n_lim, r_p, n_p;
    logic [OFS_W-1:0]   r_req, n_req, r_target, n_target;
    logic [ALIGN_W-1:0] r_align, n_align;
    logic [AIW-1:0]     r_slot, n_slot, r_fslot, n_fslot;
    logic               r_ffound, n_ffound, r_hit, n_hit, r_hnext, n_hnext;
    logic [OFS_W-1:0]   r_start, n_start, r_len, n_len, r_need, n_need, r_addr, n_addr;
    logic [PAD_W-1:0]   r_pad, n_pad;
    logic [OFS_W-1:0]   r_nx_s, n_nx_s, r_nx_l, n_nx_l, r_pv_s, n_pv_s, r_pv_l, n_pv_l;
    logic               r_done, n_done, r_inside, n_inside;
    logic [2:0]         r_status, n_status;
    logic [OFS_W-1:0]   r_daddr, n_daddr;

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            free_mem[fr_wa] <= fr_wd;
        end
        fr_q <= free_mem[fr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (al_we) begin
            alloc_mem[al_wa] <= al_wd;
        end
        al_q <= alloc_mem[al_ra];
    end

    always_comb begin
        logic [ALIGN_W-1:0] a_m1;
        logic               align_ok;
        logic [PAD_W-1:0]   pad;
        logic [OFS_W:0]     need;
        logic               fit;
        logic               ent_valid;
        logic               slot_hit;
        logic               cand;
        logic [AIW-1:0]     di_a;
        logic [OFS_W-1:0]   rest;
        logic [OFS_W-1:0]   used_new;
        logic               mnext, mprev;
        logic [OFS_W-1:0]   data_len, off;
        logic [FIW-1:0]     p_m1;

        n_state  = r_state;
        n_count  = r_count;
        n_valid  = r_valid;
        n_used   = r_used;
        n_peak   = r_peak;
        n_ptr    = r_ptr;
        n_di     = r_di;
        n_dv     = r_dv;
        n_lim    = r_lim;
        n_p      = r_p;
        n_req    = r_req;
        n_target = r_target;
        n_align  = r_align;
        n_slot   = r_slot;
        n_fslot  = r_fslot;
        n_ffound = r_ffound;
        n_hit    = r_hit;
        n_hnext  = r_hnext;
        n_start  = r_start;
        n_len    = r_len;
        n_need   = r_need;
        n_addr   = r_addr;
        n_pad    = r_pad;
        n_nx_s   = r_nx_s;
        n_nx_l   = r_nx_l;
        n_pv_s   = r_pv_s;
        n_pv_l   = r_pv_l;
        n_done   = 1'b0;
        n_status = ST_OK;
        n_daddr  = '0;
        n_inside = 1'b0;
        fr_we = 1'b0;
        fr_wa = '0;
        fr_wd = '0;
        fr_ra = '0;
        al_we = 1'b0;
        al_wa = '0;
        al_wd = '0;
        al_ra = '0;

        a_m1      = r_align - ALIGN_W'(1);
        align_ok  = (i_align_bytes >= ALIGN_W'(MIN_ALIGN)) &&
                    ((i_align_bytes & (i_align_bytes - ALIGN_W'(1))) == '0);
        pad       = (PAD_W'(0) - fr_q.start[PAD_W-1:0]) & a_m1[PAD_W-1:0];
        need      = {1'b0, r_req} + (OFS_W+1)'(pad);
        fit       = {1'b0, fr_q.len} >= need;
        di_a      = r_di[AIW-1:0];
        ent_valid = r_dv && r_valid[di_a];
        slot_hit  = 1'b0;
        cand      = 1'b0;
        rest      = r_len - r_need;
        used_new  = r_used + r_need;
        mnext     = r_hnext && ((r_start + r_len) == r_nx_s);
        mprev     = (r_p != '0) && ((r_pv_s + r_pv_l) == r_start);
        data_len  = r_len - OFS_W'(r_pad);
        off       = r_target - r_start;
        p_m1      = FIW'(r_p - FCW'(1));

        case (r_state)
            S_INIT: begin
                fr_we   = 1'b1;
                fr_wa   = '0;
                fr_wd   = '0;
                n_count = FCW'(1);
                n_valid = '0;
                n_used  = '0;
                n_peak  = '0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req    = i_request_bytes;
                    n_align  = i_align_bytes;
                    n_target = i_target_address;
                    n_ptr    = '0;
                    n_dv     = 1'b0;
                    n_addr   = '0;
                    n_hit    = 1'b0;
                    n_ffound = 1'b0;
                    case (t_opcode'(i_opcode))
                        OP_ALLOC: begin
                            if (align_ok) begin
                                n_state = S_AL_SCAN;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_ALIGN;
                            end
                        end
                        OP_FREE:  n_state = S_FR_FIND;
                        OP_CHECK: n_state = S_CK_SCAN;
                        OP_CLEAR: n_state = S_CLR;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                fr_we   = 1'b1;
                fr_wa   = '0;
                fr_wd   = '{start: i_cfg.base, len: i_cfg.bytes};
                n_count = FCW'(1);
                n_valid = '0;
                n_used  = '0;
                n_peak  = '0;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_AL_SCAN: begin
                if (r_ptr < PW'(r_count)) begin
                    fr_ra = r_ptr[FIW-1:0];
                    n_ptr = r_ptr + PW'(1);
                    n_dv  = 1'b1;
                    n_di  = r_ptr;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv && fit) begin
                    n_p      = r_di[FCW-1:0];
                    n_start  = fr_q.start;
                    n_len    = fr_q.len;
                    n_pad    = pad;
                    n_need   = need[OFS_W-1:0];
                    n_addr   = fr_q.start + OFS_W'(pad);
                    n_ptr    = '0;
                    n_dv     = 1'b0;
                    n_ffound = 1'b0;
                    n_state  = S_AL_SLOT;
                end else if (r_ptr >= PW'(r_count)) begin
                    n_done   = 1'b1;
                    n_status = ST_NO_MEMORY;
                    n_state  = S_IDLE;
                end
            end
            S_AL_SLOT: begin
                if (r_ptr < PW'(ALLOC_SLOTS)) begin
                    al_ra = r_ptr[AIW-1:0];
                    n_ptr = r_ptr + PW'(1);
                    n_dv  = 1'b1;
                    n_di  = r_ptr;
                end else begin
                    n_dv = 1'b0;
                end
                slot_hit = ent_valid && (al_q.addr == r_addr);
                cand     = r_dv && !r_valid[di_a] && !r_ffound;
                if (cand) begin
                    n_ffound = 1'b1;
                    n_fslot  = di_a;
                end
                if (slot_hit) begin
                    n_slot  = di_a;
                    n_state = S_AL_UPD;
                end else if (r_ptr >= PW'(ALLOC_SLOTS) && !r_dv) begin
                    if (r_ffound) begin
                        n_slot  = r_fslot;
                        n_state = S_AL_UPD;
                    end else begin
                        n_done   = 1'b1;
                        n_status = ST_ALLOC_FULL;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_AL_UPD: begin
                al_we = 1'b1;
                al_wa = r_slot;
                al_wd = '{addr: r_addr, len: r_need, pad: r_pad};
                n_valid[r_slot] = 1'b1;
                n_used = used_new;
                if (used_new > r_peak) begin
                    n_peak = used_new;
                end
                if (rest != '0) begin
                    fr_we   = 1'b1;
                    fr_wa   = r_p[FIW-1:0];
                    fr_wd   = '{start: r_start + r_need, len: rest};
                    n_done  = 1'b1;
                    n_daddr = r_addr;
                    n_state = S_IDLE;
                end else begin
                    n_count = r_count - FCW'(1);
                    n_lim   = r_count;
                    n_ptr   = PW'(r_p) + PW'(1);
                    n_dv    = 1'b0;
                    n_state = S_SHIFT_DN;
                end
            end
            S_SHIFT_DN: begin
                if (r_ptr < PW'(r_lim)) begin
                    fr_ra = r_ptr[FIW-1:0];
                    n_ptr = r_ptr + PW'(1);
                    n_dv  = 1'b1;
                    n_di  = r_ptr;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    fr_we = 1'b1;
                    fr_wa = FIW'(r_di - PW'(1));
                    fr_wd = fr_q;
                end
                if (r_ptr >= PW'(r_lim)) begin
                    n_done  = 1'b1;
                    n_daddr = r_addr;
                    n_state = S_IDLE;
                end
            end
            S_FR_FIND: begin
                if (r_ptr < PW'(ALLOC_SLOTS)) begin
                    al_ra = r_ptr[AIW-1:0];
                    n_ptr = r_ptr + PW'(1);
                    n_dv  = 1'b1;
                    n_di  = r_ptr;
                end else begin
                    n_dv = 1'b0;
                end
                slot_hit = ent_valid && (al_q.addr == r_target);
                if (slot_hit) begin
                    n_slot  = di_a;
                    n_len   = al_q.len;
                    n_pad   = al_q.pad;
                    n_start = r_target - OFS_W'(al_q.pad);
                    n_ptr   = '0;
                    n_dv    = 1'b0;
                    n_state = S_FR_SCAN;
                end else if (r_ptr >= PW'(ALLOC_SLOTS) && !r_dv) begin
                    n_done   = 1'b1;
                    n_status = ST_UNKNOWN;
                    n_state  = S_IDLE;
                end
            end
            S_FR_SCAN: begin
                if (r_ptr < PW'(r_count)) begin
                    fr_ra = r_ptr[FIW-1:0];
                    n_ptr = r_ptr + PW'(1);
                    n_dv  = 1'b1;
                    n_di  = r_ptr;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv && (r_start < fr_q.start)) begin
                    n_p     = r_di[FCW-1:0];
                    n_nx_s  = fr_q.start;
                    n_nx_l  = fr_q.len;
                    n_hnext = 1'b1;
                    n_state = S_FR_UPD;
                end else begin
                    if (r_dv) begin
                        n_pv_s = fr_q.start;
                        n_pv_l = fr_q.len;
                    end
                    if (r_ptr >= PW'(r_count)) begin
                        n_p     = r_count;
                        n_hnext = 1'b0;
                        n_state = S_FR_UPD;
                    end
                end
            end
            S_FR_UPD: begin
                if (!mnext && !mprev && (r_count >= FCW'(FREE_SLOTS))) begin
                    n_done   = 1'b1;
                    n_status = ST_FREE_FULL;
                    n_state  = S_IDLE;
                end else begin
                    n_valid[r_slot] = 1'b0;
                    n_used = r_used - r_len;
                    if (mprev && mnext) begin
                        fr_we   = 1'b1;
                        fr_wa   = p_m1;
                        fr_wd   = '{start: r_pv_s, len: r_pv_l + r_len + r_nx_l};
                        n_count = r_count - FCW'(1);
                        n_lim   = r_count;
                        n_ptr   = PW'(r_p) + PW'(1);
                        n_dv    = 1'b0;
                        n_state = S_SHIFT_DN;
                    end else if (mprev) begin
                        fr_we   = 1'b1;
                        fr_wa   = p_m1;
                        fr_wd   = '{start: r_pv_s, len: r_pv_l + r_len};
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else if (mnext) begin
                        fr_we   = 1'b1;
                        fr_wa   = r_p[FIW-1:0];
                        fr_wd   = '{start: r_start, len: r_nx_l + r_len};
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_count = r_count + FCW'(1);
                        n_ptr   = PW'(r_count);
                        n_dv    = 1'b0;
                        n_state = S_SHIFT_UP;
                    end
                end
            end
            S_SHIFT_UP: begin
                if (r_ptr > PW'(r_p)) begin
                    fr_ra = FIW'(r_ptr - PW'(1));
                    n_ptr = r_ptr - PW'(1);
                    n_dv  = 1'b1;
                    n_di  = r_ptr - PW'(1);
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    fr_we = 1'b1;
                    fr_wa = FIW'(r_di + PW'(1));
                    fr_wd = fr_q;
                end else if (r_ptr <= PW'(r_p)) begin
                    fr_we   = 1'b1;
                    fr_wa   = r_p[FIW-1:0];
                    fr_wd   = '{start: r_start, len: r_len};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CK_SCAN: begin
                if (r_ptr < PW'(ALLOC_SLOTS)) begin
                    al_ra = r_ptr[AIW-1:0];
                    n_ptr = r_ptr + PW'(1);
                    n_dv  = 1'b1;
                    n_di  = r_ptr;
                end else begin
                    n_dv = 1'b0;
                end
                cand = ent_valid && (al_q.addr <= r_target) &&
                       (!r_hit || (al_q.addr > r_start));
                if (cand) begin
                    n_hit   = 1'b1;
                    n_start = al_q.addr;
                    n_len   = al_q.len;
                    n_pad   = al_q.pad;
                end
                if (r_ptr >= PW'(ALLOC_SLOTS) && !r_dv) begin
                    n_state = S_CK_EVAL;
                end
            end
            S_CK_EVAL: begin
                n_done   = 1'b1;
                n_inside = r_hit && (r_req <= data_len) && (off <= data_len - r_req);
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= FCW'(1);
            r_valid <= '0;
            r_used  <= '0;
            r_peak  <= '0;
            r_ptr   <= '0;
            r_dv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_used  <= n_used;
            r_peak  <= n_peak;
            r_ptr   <= n_ptr;
            r_dv    <= n_dv;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_di     <= n_di;
        r_lim    <= n_lim;
        r_p      <= n_p;
        r_req    <= n_req;
        r_target <= n_target;
        r_align  <= n_align;
        r_slot   <= n_slot;
        r_fslot  <= n_fslot;
        r_ffound <= n_ffound;
        r_hit    <= n_hit;
        r_hnext  <= n_hnext;
        r_start  <= n_start;
        r_len    <= n_len;
        r_need   <= n_need;
        r_addr   <= n_addr;
        r_pad    <= n_pad;
        r_nx_s   <= n_nx_s;
        r_nx_l   <= n_nx_l;
        r_pv_s   <= n_pv_s;
        r_pv_l   <= n_pv_l;
        r_status <= n_status;
        r_daddr  <= n_daddr;
        r_inside <= n_inside;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_data_address = r_daddr;
    assign o_range_inside = r_inside;
    assign o_used_bytes   = r_used;
    assign o_peak_bytes   = r_peak;

endmodule

// ----- rtl/core/first_fit_offset_allocator_top.sv -----
`timescale 1ns / 1ps

// Hands out offsets inside a region set by two registers on the APB port.
// A word is taken when start is high while busy is low: opcode 0 allocates,
// 1 frees, 2 checks a range and 3 clears all tables back to one free region.
// Exactly one result word follows, shown for one cycle with o_done high.
// The receiver cannot stall; it must take each result word as it appears.
// Free regions and allocations live in two memories with registered reads
// that are walked one entry per cycle. An allocate scans the free list and
// then the allocation slots, and shifts the free list down when a region is
// used up; a free scans the allocation slots and then the free list, and may
// shift it up or down; a check scans the allocation slots. The block takes
// no new word while busy. A bad alignment is answered in the next cycle
// and the block stays ready for the following word.
// After reset the block is busy for one cycle while it writes the first
// free entry. Register writes take effect at the next clear.
module first_fit_offset_allocator_top #(
    parameter int FREE_SLOTS  = ffa_pkg::FREE_SLOTS_DEF,
    parameter int ALLOC_SLOTS = ffa_pkg::ALLOC_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic [31:0]                 i_request_bytes,
    input  logic [8:0]                  i_align_bytes,
    input  logic [31:0]                 i_target_address,
    output logic                        o_done,
    output logic [2:0]                  o_status,
    output logic [31:0]                 o_data_address,
    output logic                        o_range_inside,
    output logic [31:0]                 o_used_bytes,
    output logic [31:0]                 o_peak_bytes
);
    import ffa_pkg::*;

    t_cfg cfg;

    ffa_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ffa_ctrl #(
        .FREE_SLOTS  (FREE_SLOTS),
        .ALLOC_SLOTS (ALLOC_SLOTS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_start          (start),
        .o_busy           (busy),
        .i_opcode         (i_opcode),
        .i_request_bytes  (i_request_bytes),
        .i_align_bytes    (i_align_bytes),
        .i_target_address (i_target_address),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_data_address   (o_data_address),
        .o_range_inside   (o_range_inside),
        .o_used_bytes     (o_used_bytes),
        .o_peak_bytes     (o_peak_bytes)
    );

endmodule
